// ===== rtl/drtm_pkg.sv =====
// ----------------------------------------------------------------------------
// drtm_pkg
// shared types, codes and defaults of the descriptor ratio-test matcher
// ----------------------------------------------------------------------------
package drtm_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_DESC_LEN   = 64;
    localparam int DEF_ELEM_BITS  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] THR_RESET = 16'h8000;
    localparam int THR_SHIFT = 30;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // ratio test 25*best < 16*second
    localparam int RATIO_BEST   = 25;
    localparam int RATIO_SECOND = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_QSTART,
        S_TRD,
        S_TSTART,
        S_STREAM,
        S_DRAIN,
        S_UPDATE,
        S_DECIDE,
        S_T2,
        S_MLO,
        S_MHI,
        S_SUM,
        S_ERD,
        S_ECHK,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic load;
        logic init;
        logic used_clr;
        logic used_rd;
        logic best_clear;
        logic acc_start;
        logic rd_en;
        logic cand_update;
        logic keep_try;
        logic mul_t2;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic kept_rd;
        logic emit_chk;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic acc_busy;
        logic used_j;
        logic out_free;
        logic pass;
        logic pend_v;
    } t_stat;

endpackage

// ===== rtl/drtm_ram.sv =====
// ----------------------------------------------------------------------------
// drtm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module drtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/drtm_ctrl.sv =====
// ----------------------------------------------------------------------------
// drtm_ctrl
// sequencer of the matcher: query, target and element loops, emission
// ----------------------------------------------------------------------------
module drtm_ctrl #(
    parameter int MAX_POINTS = drtm_pkg::DEF_MAX_POINTS,
    parameter int DESC_LEN   = drtm_pkg::DEF_DESC_LEN,
    localparam int PW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int EW = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_kind,
    output logic            o_stall,
    input  drtm_pkg::t_stat i_stat,
    input  logic [CW-1:0]   i_qn,
    input  logic [CW-1:0]   i_tn,
    input  logic [CW-1:0]   i_kept_count,
    output drtm_pkg::t_cmd  o_cmd,
    output logic [PW-1:0]   o_qi,
    output logic [PW-1:0]   o_tj,
    output logic [EW-1:0]   o_elem,
    output logic [PW-1:0]   o_k
);

    import drtm_pkg::*;

    t_state r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [EW-1:0] r_e, n_e;
    logic w_accept;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_e     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_e     <= n_e;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_e     = r_e;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_kind == KIND_RUN) begin
                    o_cmd.init = 1'b1;
                    n_i        = '0;
                    n_j        = '0;
                    n_state    = S_CLR;
                end else if (w_accept) begin
                    o_cmd.load = 1'b1;
                end
            end
            // one used flag cleared per cycle
            S_CLR: begin
                o_cmd.used_clr = 1'b1;
                if (r_j == CW'(MAX_POINTS - 1)) begin
                    n_state = S_QSTART;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_QSTART: begin
                if (r_i == i_qn) begin
                    n_state = S_T2;
                end else begin
                    o_cmd.best_clear = 1'b1;
                    n_j              = '0;
                    n_state          = S_TRD;
                end
            end
            S_TRD: begin
                if (r_j == i_tn) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.used_rd = 1'b1;
                    n_state       = S_TSTART;
                end
            end
            S_TSTART: begin
                if (i_stat.used_j) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_TRD;
                end else begin
                    o_cmd.acc_start = 1'b1;
                    n_e             = '0;
                    n_state         = S_STREAM;
                end
            end
            S_STREAM: begin
                o_cmd.rd_en = 1'b1;
                if (r_e == EW'(DESC_LEN - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.acc_busy) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.cand_update = 1'b1;
                n_j               = r_j + 1'b1;
                n_state           = S_TRD;
            end
            S_DECIDE: begin
                o_cmd.keep_try = 1'b1;
                n_i            = r_i + 1'b1;
                n_state        = S_QSTART;
            end
            S_T2: begin
                o_cmd.mul_t2 = 1'b1;
                n_state      = S_MLO;
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_k       = '0;
                n_state   = S_ERD;
            end
            S_ERD: begin
                if (r_k == i_kept_count) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.kept_rd = 1'b1;
                    n_state       = S_ECHK;
                end
            end
            S_ECHK: begin
                if (!i_stat.pass) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_ERD;
                end else if (!i_stat.pend_v || i_stat.out_free) begin
                    o_cmd.emit_chk = 1'b1;
                    n_k            = r_k + 1'b1;
                    n_state        = S_ERD;
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_qi   = r_i[PW-1:0];
    assign o_tj   = r_j[PW-1:0];
    assign o_k    = r_k[PW-1:0];
    assign o_elem = r_e;

endmodule

// ===== rtl/drtm_dp.sv =====
// ----------------------------------------------------------------------------
// drtm_dp
// datapath: stores, distance pipeline, ratio test, threshold and output
// ----------------------------------------------------------------------------
module drtm_dp #(
    parameter int MAX_POINTS = drtm_pkg::DEF_MAX_POINTS,
    parameter int DESC_LEN   = drtm_pkg::DEF_DESC_LEN,
    parameter int ELEM_BITS  = drtm_pkg::DEF_ELEM_BITS,
    localparam int PW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int EW = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [drtm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drtm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_set_select,
    input  logic [5:0]                    i_point_index,
    input  logic [5:0]                    i_element_index,
    input  logic signed [15:0]            i_element_value,
    input  logic                          i_point_sign,
    input  drtm_pkg::t_cmd                i_cmd,
    input  logic [PW-1:0]                 i_qi,
    input  logic [PW-1:0]                 i_tj,
    input  logic [EW-1:0]                 i_elem,
    input  logic [PW-1:0]                 i_k,
    output drtm_pkg::t_stat               o_stat,
    output logic [CW-1:0]                 o_qn,
    output logic [CW-1:0]                 o_tn,
    output logic [CW-1:0]                 o_kept_count,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_pair_valid,
    output logic [5:0]                    o_first_index,
    output logic [5:0]                    o_second_index,
    output logic                          o_last
);

    import drtm_pkg::*;

    localparam int DEPTH = 2 * MAX_POINTS * DESC_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = ELEM_BITS + 1;
    localparam int SUMW  = 2 * ELEM_BITS + $clog2(DESC_LEN + 1);
    localparam int KW    = SUMW + 5;
    localparam int KEPTW = 2 * PW + SUMW;
    localparam int RW    = 96;

    // configuration
    logic [COUNT_W-1:0]    r_count_first, r_count_second;
    logic [CFG_DATA_W-1:0] r_thr;
    logic [CW-1:0]         w_c1, w_c2;
    logic                  w_qset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_first  <= '0;
            r_count_second <= '0;
            r_thr          <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COUNT_FIRST:  r_count_first  <= i_cfg_data[COUNT_W-1:0];
                CFG_COUNT_SECOND: r_count_second <= i_cfg_data[COUNT_W-1:0];
                CFG_THRESHOLD:    r_thr          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_c1 = (r_count_first > COUNT_W'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                          : CW'(r_count_first);
    assign w_c2 = (r_count_second > COUNT_W'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                           : CW'(r_count_second);
    assign w_qset = (w_c2 <= w_c1);
    assign o_qn   = w_qset ? w_c2 : w_c1;
    assign o_tn   = w_qset ? w_c1 : w_c2;

    // descriptor stores, sign kept beside every element and read at element zero
    logic [ELEM_BITS+15:0] w_wide;
    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_qaddr, w_taddr;
    logic [DW-1:0]         w_wdata, w_qdata, w_tdata;

    assign w_wide  = {{ELEM_BITS{1'b0}}, i_element_value};
    assign w_wdata = {i_point_sign, w_wide[ELEM_BITS-1:0]};
    assign w_we    = i_cmd.load && (32'(i_point_index) < MAX_POINTS)
                     && (32'(i_element_index) < DESC_LEN);
    assign w_waddr = AW'((AW'(i_set_select) * AW'(MAX_POINTS) + AW'(i_point_index))
                     * AW'(DESC_LEN) + AW'(i_element_index));
    assign w_qaddr = AW'((AW'(w_qset) * AW'(MAX_POINTS) + AW'(i_qi))
                     * AW'(DESC_LEN) + AW'(i_elem));
    assign w_taddr = AW'((AW'(!w_qset) * AW'(MAX_POINTS) + AW'(i_tj))
                     * AW'(DESC_LEN) + AW'(i_elem));

    drtm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_qstore (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_qaddr),
        .o_rdata (w_qdata)
    );

    drtm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_tstore (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_taddr),
        .o_rdata (w_tdata)
    );

    // distance pipeline: read, square, accumulate
    logic                   r_v1, r_v2, r_first1;
    logic                   r_qsign, r_tsign;
    logic [2*ELEM_BITS-1:0] r_sq;
    logic [SUMW-1:0]        r_acc;
    logic signed [ELEM_BITS:0] w_diff;
    logic [ELEM_BITS:0]     w_neg;
    logic [ELEM_BITS-1:0]   w_abs;

    assign w_diff = $signed({w_qdata[ELEM_BITS-1], w_qdata[ELEM_BITS-1:0]})
                  - $signed({w_tdata[ELEM_BITS-1], w_tdata[ELEM_BITS-1:0]});
    assign w_neg  = -w_diff;
    assign w_abs  = w_diff[ELEM_BITS] ? w_neg[ELEM_BITS-1:0] : w_diff[ELEM_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= i_cmd.rd_en && (i_elem == '0);
        r_sq     <= w_abs * w_abs;
        if (r_v1 && r_first1) begin
            r_qsign <= w_qdata[ELEM_BITS];
            r_tsign <= w_tdata[ELEM_BITS];
        end
        if (i_cmd.acc_start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + SUMW'(r_sq);
        end
    end

    // nearest and second nearest of one query
    logic            r_have_b, r_have_s;
    logic [SUMW-1:0] r_best, r_second;
    logic [PW-1:0]   r_best_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.best_clear) begin
            r_have_b <= 1'b0;
            r_have_s <= 1'b0;
        end else if (i_cmd.cand_update && r_qsign == r_tsign) begin
            if (!r_have_b) begin
                r_have_b   <= 1'b1;
                r_best     <= r_acc;
                r_best_idx <= i_tj;
            end else if (r_acc < r_best) begin
                r_second   <= r_best;
                r_have_s   <= 1'b1;
                r_best     <= r_acc;
                r_best_idx <= i_tj;
            end else if (!r_have_s || r_acc < r_second) begin
                r_second   <= r_acc;
                r_have_s   <= 1'b1;
            end
        end
    end

    logic w_keep;
    assign w_keep = r_have_b && r_have_s && (r_second != '0)
                    && (KW'(r_best) * KW'(RATIO_BEST) < KW'(r_second) * KW'(RATIO_SECOND));

    // kept pairs, largest kept distance
    logic [CW-1:0]         r_kept_count;
    logic [SUMW-1:0]       r_largest;
    logic                  w_kept_we;
    logic [KEPTW-1:0]      w_kept_rdata;

    assign w_kept_we = i_cmd.keep_try && w_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_count <= '0;
            r_largest    <= '0;
        end else if (i_cmd.init) begin
            r_kept_count <= '0;
            r_largest    <= '0;
        end else if (w_kept_we) begin
            r_kept_count       <= r_kept_count + 1'b1;
            if (r_best > r_largest) begin
                r_largest <= r_best;
            end
        end
    end

    drtm_ram #(.WIDTH(KEPTW), .DEPTH(MAX_POINTS)) u_kept (
        .i_clk   (i_clk),
        .i_we    (w_kept_we),
        .i_waddr (r_kept_count[PW-1:0]),
        .i_wdata ({i_qi, r_best_idx, r_best}),
        .i_re    (i_cmd.kept_rd),
        .i_raddr (i_k),
        .o_rdata (w_kept_rdata)
    );

    assign o_kept_count = r_kept_count;

    // used targets: cleared by the sequencer at run start, set on a kept pair
    logic          w_used_we;
    logic [PW-1:0] w_used_waddr;
    logic          w_used_rdata;

    assign w_used_we    = i_cmd.used_clr || w_kept_we;
    assign w_used_waddr = i_cmd.used_clr ? i_tj : r_best_idx;

    drtm_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_used (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (w_used_waddr),
        .i_wdata (!i_cmd.used_clr),
        .i_re    (i_cmd.used_rd),
        .i_raddr (i_tj),
        .o_rdata (w_used_rdata)
    );

    // threshold product t^2 * largest, built from t^2, low and high partial products and their sum
    logic [31:0]   r_t2;
    logic [63:0]   r_plo, r_phi, w_maxpad;
    logic [RW-1:0] r_rhs, w_lhs;

    assign w_maxpad = 64'(r_largest);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_t2) begin
            r_t2 <= r_thr * r_thr;
        end
        if (i_cmd.mul_lo) begin
            r_plo <= r_t2 * w_maxpad[31:0];
        end
        if (i_cmd.mul_hi) begin
            r_phi <= r_t2 * w_maxpad[63:32];
        end
        if (i_cmd.sum) begin
            r_rhs <= RW'(r_plo) + (RW'(r_phi) << 32);
        end
    end

    assign w_lhs = RW'(w_kept_rdata[SUMW-1:0]) << THR_SHIFT;

    // pending pair and output register
    logic          r_pend_v;
    logic [PW-1:0] r_pend_q, r_pend_t;
    logic          r_ovalid, n_ovalid;
    logic          r_opair, n_opair, r_olast, n_olast;
    logic [5:0]    r_ofirst, n_ofirst, r_osecond, n_osecond;
    logic          w_push;

    assign w_push = (i_cmd.emit_chk && r_pend_v) || i_cmd.emit_final;

    always_comb begin
        n_ovalid  = r_ovalid && i_stall;
        n_opair   = r_opair;
        n_olast   = r_olast;
        n_ofirst  = r_ofirst;
        n_osecond = r_osecond;
        if (w_push) begin
            n_ovalid  = 1'b1;
            n_opair   = r_pend_v;
            n_olast   = i_cmd.emit_final;
            n_ofirst  = '0;
            n_osecond = '0;
            if (r_pend_v) begin
                n_ofirst  = 6'(w_qset ? r_pend_t : r_pend_q);
                n_osecond = 6'(w_qset ? r_pend_q : r_pend_t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (i_cmd.init || i_cmd.emit_final) begin
                r_pend_v <= 1'b0;
            end else if (i_cmd.emit_chk) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_opair   <= n_opair;
        r_olast   <= n_olast;
        r_ofirst  <= n_ofirst;
        r_osecond <= n_osecond;
        if (i_cmd.emit_chk) begin
            r_pend_q <= w_kept_rdata[KEPTW-1 -: PW];
            r_pend_t <= w_kept_rdata[SUMW +: PW];
        end
    end

    assign o_valid        = r_ovalid;
    assign o_pair_valid   = r_opair;
    assign o_first_index  = r_ofirst;
    assign o_second_index = r_osecond;
    assign o_last         = r_olast;

    assign o_stat.acc_busy = r_v1 || r_v2;
    assign o_stat.used_j   = w_used_rdata;
    assign o_stat.out_free = !r_ovalid || !i_stall;
    assign o_stat.pass     = (w_lhs <= r_rhs);
    assign o_stat.pend_v   = r_pend_v;

endmodule

// ===== rtl/descriptor_ratio_test_matcher.sv =====
// ----------------------------------------------------------------------------
// descriptor_ratio_test_matcher
// nearest-neighbor ratio-test matcher of two signed descriptor sets
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  kind, set_select, point_index,
//                                          element_index, element_value,
//                                          point_sign
//  result    out        o_valid / i_stall  pair_valid, first_index,
//                                          second_index, last
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
//  a load transfer with indices in range writes both descriptor store copies
//  a run streams every element of each unused target of each query through
//  the distance pipeline, one element a cycle, skips used targets, and waits
//  on result stalls
//  o_stall stays high from a run transfer until its last result is loaded
//  into the output register; a stalled result holds in that register
//  reset (synchronous, active low) clears control state and the registers
//  to zero, zero and half scale; each run opens with a clearing pass over
//  every used-target flag
//
module descriptor_ratio_test_matcher #(
    parameter int MAX_POINTS = drtm_pkg::DEF_MAX_POINTS,
    parameter int DESC_LEN   = drtm_pkg::DEF_DESC_LEN,
    parameter int ELEM_BITS  = drtm_pkg::DEF_ELEM_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [drtm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drtm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_kind,
    input  logic                            i_set_select,
    input  logic [5:0]                      i_point_index,
    input  logic [5:0]                      i_element_index,
    input  logic signed [15:0]              i_element_value,
    input  logic                            i_point_sign,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_pair_valid,
    output logic [5:0]                      o_first_index,
    output logic [5:0]                      o_second_index,
    output logic                            o_last
);

    import drtm_pkg::*;

    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int EW = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;

    // command and status between sequencer and datapath
    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [PW-1:0] w_qi, w_tj, w_k;
    logic [EW-1:0] w_elem;
    logic [CW-1:0] w_qn, w_tn, w_kept_count;

    drtm_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .DESC_LEN   (DESC_LEN)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_kind       (i_kind),
        .o_stall      (o_stall),
        .i_stat       (w_stat),
        .i_qn         (w_qn),
        .i_tn         (w_tn),
        .i_kept_count (w_kept_count),
        .o_cmd        (w_cmd),
        .o_qi         (w_qi),
        .o_tj         (w_tj),
        .o_elem       (w_elem),
        .o_k          (w_k)
    );

    drtm_dp #(
        .MAX_POINTS (MAX_POINTS),
        .DESC_LEN   (DESC_LEN),
        .ELEM_BITS  (ELEM_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_set_select    (i_set_select),
        .i_point_index   (i_point_index),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_point_sign    (i_point_sign),
        .i_cmd           (w_cmd),
        .i_qi            (w_qi),
        .i_tj            (w_tj),
        .i_elem          (w_elem),
        .i_k             (w_k),
        .o_stat          (w_stat),
        .o_qn            (w_qn),
        .o_tn            (w_tn),
        .o_kept_count    (w_kept_count),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_pair_valid    (o_pair_valid),
        .o_first_index   (o_first_index),
        .o_second_index  (o_second_index),
        .o_last          (o_last)
    );

    // a run transfer makes the block busy in the next cycle
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_kind == KIND_RUN) |=> o_stall)
        else $error("run transfer did not start the sequencer");

    // the closing result of a run always lands in the output register
    a_final_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_final |=> (o_valid && o_last))
        else $error("final result not presented");

    // a run starts with an empty list of kept pairs
    a_init_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.init |=> (w_kept_count == '0))
        else $error("kept pair count not cleared at run start");

endmodule
